### hdl/assert_macros.svh
// assertion helpers shared by rarm_front and rarm_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/rarm_pkg.sv
// ---------------------------------------------------------------------------
// rarm_pkg
// shared operation codes for the rational add / multiply / reduce block
// ---------------------------------------------------------------------------
package rarm_pkg;

  localparam logic KIND_MUL = 1'b0;
  localparam logic KIND_ADD = 1'b1;

endpackage

### hdl/rarm_front.sv
// ---------------------------------------------------------------------------
// rarm_front
// accepts items, forms raw numerator and denominator in F_MUL1 and F_MUL2 and
// pushes them into a two-entry queue
// ---------------------------------------------------------------------------
module rarm_front import rarm_pkg::*; #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic signed [W-1:0]   a_num,
  input  logic signed [W-1:0]   a_den,
  input  logic signed [W-1:0]   b_num,
  input  logic signed [W-1:0]   b_den,
  output logic                  q_valid,
  input  logic                  q_pop,
  output logic signed [2*W:0]   q_num,
  output logic signed [2*W-1:0] q_den
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL1 = 4'b0010,
    F_MUL2 = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state;
  logic op;
  logic signed [W-1:0] an, ad, bn, bd;
  logic signed [2*W-1:0] p0, p1;
  logic signed [2*W:0] num;
  logic signed [2*W-1:0] den;

  logic signed [2*W:0]   qn [2];
  logic signed [2*W-1:0] qd [2];
  logic [1:0] cnt;
  logic wp, rp;
  logic push;

  assign in_stall = (state != F_IDLE);
  assign push = (state == F_PUSH) && (cnt != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (in_valid) state <= F_MUL1;
        F_MUL1: state <= F_MUL2;
        F_MUL2: state <= F_PUSH;
        F_PUSH: if (push) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  // straight products in F_MUL1, cross products for add in F_MUL2
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: if (in_valid) begin
        op <= kind; an <= a_num; ad <= a_den; bn <= b_num; bd <= b_den;
      end
      F_MUL1: begin
        p0 <= an * bn;
        p1 <= ad * bd;
      end
      F_MUL2: begin
        den <= p1;
        if (op == KIND_ADD) begin
          num <= (2*W+1)'(an * bd) + (2*W+1)'(ad * bn);
        end else begin
          num <= (2*W+1)'(p0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; wp <= 1'b0; rp <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qn[wp] <= num;
      qd[wp] <= den;
    end
  end

  assign q_valid = (cnt != 2'd0);
  assign q_num = qn[rp];
  assign q_den = qd[rp];

`include "assert_macros.svh"
  `ASSERT_IMPL(a_no_over, clk, rst, cnt == 2'd2, !push)
  `ASSERT_IMPL(a_no_under, clk, rst, q_pop, q_valid)
  `ASSERT_IMPL(a_cnt_max, clk, rst, 1'b1, cnt <= 2'd2)

endmodule

### hdl/rarm_back.sv
// ---------------------------------------------------------------------------
// rarm_back
// binary gcd and two restoring divisions on the raw fraction, if positive
// ---------------------------------------------------------------------------
module rarm_back #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic signed [2*W:0]   q_num,
  input  logic signed [2*W-1:0] q_den,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [2*W:0]   raw_num,
  output logic signed [2*W-1:0] raw_den,
  output logic signed [2*W:0]   reduced_num,
  output logic signed [2*W-1:0] reduced_den
);

  localparam int NW = 2*W + 1;
  localparam int CW = $clog2(NW + 1);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_GCD  = 5'b00010,
    B_DIV  = 5'b00100,
    B_DONE = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_t;

  bstate_t state;
  logic [NW-1:0] x, y, g;
  logic [CW-1:0] sh, cnt;
  // divider working registers: quotient/remainder for num and den in parallel
  logic [NW-1:0] qa, qb, ra, rb;
  logic [NW-1:0] ra_s, rb_s;
  logic positive;

  assign q_pop = (state == B_IDLE) && q_valid;
  assign out_valid = (state == B_OUT);
  assign positive = !q_num[NW-1] && (q_num != '0) && !q_den[2*W-1] && (q_den != '0);
  assign ra_s = {ra[NW-2:0], qa[NW-1]};
  assign rb_s = {rb[NW-2:0], qb[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: if (q_valid) state <= positive ? B_GCD : B_OUT;
        B_GCD: if (x == y) state <= B_DIV;
        B_DIV: if (cnt == CW'(NW - 1)) state <= B_DONE;
        B_DONE: state <= B_OUT;
        B_OUT: if (!out_stall) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: if (q_valid) begin
        raw_num <= q_num;
        raw_den <= q_den;
        reduced_num <= q_num;
        reduced_den <= q_den;
        x <= q_num;
        y <= NW'(q_den);
        sh <= '0;
      end
      // binary gcd, one step a cycle
      B_GCD: begin
        if (x == y) begin
          g <= x << sh;
          cnt <= '0;
          qa <= raw_num; qb <= NW'(raw_den);
          ra <= '0; rb <= '0;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1; y <= y >> 1; sh <= sh + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= (x - y) >> 1;
        end else begin
          y <= (y - x) >> 1;
        end
      end
      // restoring division, one quotient bit a cycle
      B_DIV: begin
        cnt <= cnt + 1'b1;
        if (ra_s >= g) begin
          ra <= ra_s - g; qa <= {qa[NW-2:0], 1'b1};
        end else begin
          ra <= ra_s; qa <= {qa[NW-2:0], 1'b0};
        end
        if (rb_s >= g) begin
          rb <= rb_s - g; qb <= {qb[NW-2:0], 1'b1};
        end else begin
          rb <= rb_s; qb <= {qb[NW-2:0], 1'b0};
        end
      end
      B_DONE: begin
        reduced_num <= qa;
        reduced_den <= qb[2*W-1:0];
      end
      default: ;
    endcase
  end

`include "assert_macros.svh"
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(reduced_num))
  `ASSERT_IMPL(a_gcd_nz, clk, rst, state == B_DIV, g != '0)
  `ASSERT_NEXT(a_pop_leaves, clk, rst, q_pop, state != B_IDLE)

endmodule

### hdl/rational_add_multiply_reduce_top.sv
// ---------------------------------------------------------------------------
// rational_add_multiply_reduce_top
// rational add or multiply with gcd reduction of the result
// ---------------------------------------------------------------------------
// the back part takes one item at a time: a binary gcd, then a restoring divider, one step a cycle each
// non-positive fractions skip reduction
// the front accepts the next item while the back works (two-entry queue)
// reset is synchronous and clears all control state
module rational_add_multiply_reduce_top import rarm_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic signed [OPERAND_WIDTH-1:0]   a_num,
  input  logic signed [OPERAND_WIDTH-1:0]   a_den,
  input  logic signed [OPERAND_WIDTH-1:0]   b_num,
  input  logic signed [OPERAND_WIDTH-1:0]   b_den,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [2*OPERAND_WIDTH:0]   raw_num,
  output logic signed [2*OPERAND_WIDTH-1:0] raw_den,
  output logic signed [2*OPERAND_WIDTH:0]   reduced_num,
  output logic signed [2*OPERAND_WIDTH-1:0] reduced_den
);

  logic q_valid, q_pop;
  logic signed [2*OPERAND_WIDTH:0]   q_num;
  logic signed [2*OPERAND_WIDTH-1:0] q_den;

  rarm_front #(.W(OPERAND_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .a_num, .a_den, .b_num, .b_den,
    .q_valid, .q_pop, .q_num, .q_den
  );

  rarm_back #(.W(OPERAND_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_num, .q_den,
    .out_valid, .out_stall, .raw_num, .raw_den, .reduced_num, .reduced_den
  );

endmodule

### verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// checks rational add / multiply with gcd reduction against a local
// predictor; directed corner items then random items with random gaps and
// stalls on both channels, one long receiver hold-off and one drain pause
// ---------------------------------------------------------------------------
module tb;
  import rarm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W  = 16;
  localparam int NW = 2 * W + 1;
  localparam int DW = 2 * W;
  localparam int N_RANDOM = 2000;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [NW-1:0] raw_num;
    logic signed [DW-1:0] raw_den;
    logic signed [NW-1:0] red_num;
    logic signed [DW-1:0] red_den;
  } fraction_t;

  class fraction_board;
    fraction_t pending[$];
    int errors;
    int checked;

    function longint unsigned gcd64(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    function void note_item(logic k, logic signed [W-1:0] an, logic signed [W-1:0] ad,
                            logic signed [W-1:0] bn, logic signed [W-1:0] bd);
      longint n, d;
      longint unsigned g;
      fraction_t f;
      if (k == KIND_ADD) n = longint'(an) * longint'(bd) + longint'(ad) * longint'(bn);
      else n = longint'(an) * longint'(bn);
      d = longint'(ad) * longint'(bd);
      f.raw_num = n[NW-1:0];
      f.raw_den = d[DW-1:0];
      f.red_num = f.raw_num;
      f.red_den = f.raw_den;
      if (n > 0 && d > 0) begin
        g = gcd64(n, d);
        f.red_num = NW'(longint'(n) / longint'(g));
        f.red_den = DW'(longint'(d) / longint'(g));
      end
      pending.push_back(f);
    endfunction

    function void check_result(fraction_t got);
      fraction_t exp_f;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_f = pending.pop_front();
      checked++;
      if (got !== exp_f) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p got %p", exp_f, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = KIND_MUL;
  logic signed [W-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NW-1:0] raw_num, reduced_num;
  logic signed [DW-1:0] raw_den, reduced_den;

  fraction_board board = new();
  longint cycles = 0;
  bit hold_off = 1'b0;
  int long_hold_cycles = 0;

  rational_add_multiply_reduce_top #(.OPERAND_WIDTH(W)) dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
  endfunction

  // accept results and check them against the board
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result('{raw_num, raw_den, reduced_num, reduced_den});
  end

  initial begin : receiver
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 600; i++) begin
          @(posedge clk);
          long_hold_cycles++;
        end
        hold_off = 1'b0;
      end
      n = gap_len();
      out_stall <= (n > 0) && ($urandom_range(0, 3) != 0);
      repeat (n + 1) @(posedge clk);
    end
  end

  function automatic logic signed [W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return 16'sd1;
      4: return -16'sd1;
      5: return W'($urandom_range(1, 60));
      6: return -W'($urandom_range(1, 60));
      default: return W'($urandom);
    endcase
  endfunction

  task automatic send(logic k, logic signed [W-1:0] an, logic signed [W-1:0] ad,
                      logic signed [W-1:0] bn, logic signed [W-1:0] bd);
    in_valid <= 1'b1;
    kind <= k;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(k, an, ad, bn, bd);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin : sender
    int wait_cycles;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // corners: extremes, zero and negative parts, reducible fractions
    send(KIND_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send(KIND_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send(KIND_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send(KIND_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send(KIND_ADD, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send(KIND_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send(KIND_MUL, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send(KIND_MUL, 16'sd6, 16'sd4, 16'sd10, 16'sd15);
    send(KIND_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
    send(KIND_ADD, 16'sd1, 16'sd3, -16'sd1, 16'sd3);
    send(KIND_MUL, 16'sd0, 16'sd5, 16'sd7, 16'sd9);
    send(KIND_MUL, 16'sd3, 16'sd0, 16'sd7, 16'sd9);
    send(KIND_ADD, 16'sd3, 16'sd0, 16'sd7, 16'sd0);
    send(KIND_MUL, -16'sd4, 16'sd6, 16'sd2, 16'sd8);
    send(KIND_MUL, -16'sd4, -16'sd6, -16'sd2, -16'sd8);
    send(KIND_ADD, 16'sd5, -16'sd10, 16'sd3, 16'sd6);
    send(KIND_MUL, 16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
    send(KIND_ADD, 16'sd12, 16'sd18, 16'sd20, 16'sd30);
    idle_gap(1);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == 1000) begin
        // let everything drain before continuing
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
      end
      send(logic'($urandom_range(0, 1)), pick_value(), pick_value(), pick_value(),
           pick_value());
      if ($urandom_range(0, 3) == 0) idle_gap(gap_len());
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    wait_cycles = 200;
    repeat (wait_cycles) @(posedge clk);
    $display("tb: %0d results checked over %0d cycles; corners, random mix, %0d-cycle hold",
             board.checked, cycles, long_hold_cycles);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
